### hw/rtl/cmbd_pkg.sv
// Package for the console memory bus decoder: payload types, targets and tables.
package cmbd_pkg;

    localparam int WORK_RAM_BYTES = 8192;
    localparam int SPRITE_RAM_BYTES = 160;

    typedef enum logic [2:0] {
        TGT_INTERNAL = 3'd0,
        TGT_CART     = 3'd1,
        TGT_BOOT     = 3'd2,
        TGT_TIMER    = 3'd3,
        TGT_AUDIO    = 3'd4,
        TGT_JOYPAD   = 3'd5,
        TGT_UNMAPPED = 3'd6
    } target_t;

    // Which internal store an access reaches.
    typedef enum logic [2:0] {
        SEL_NONE   = 3'd0,
        SEL_VRAM   = 3'd1,
        SEL_WRAM   = 3'd2,
        SEL_OAM    = 3'd3,
        SEL_HRAM   = 3'd4,
        SEL_LOCAL  = 3'd5
    } sel_t;

    typedef struct packed {
        logic       kind;
        logic [15:0] address;
        logic [7:0] write_data;
        logic [7:0] external_data;
        logic [7:0] current_line;
        logic [2:0] display_mode_bits;
    } access_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic [2:0] target;
        logic       external_write;
        logic       serial_valid;
        logic [7:0] serial_out;
        logic       dma_start;
        logic [7:0] dma_page;
        logic [7:0] interrupt_enable;
        logic [7:0] interrupt_flags;
    } result_t;

    // Memory request from the decoder to the RAM bank.
    typedef struct packed {
        sel_t        sel;
        logic        wr;
        logic [12:0] index;
        logic [7:0]  data;
    } mem_req_t;

    function automatic logic [7:0] audio_mask(input logic [4:0] idx);
        logic [7:0] m;
        begin
            unique case (idx)
                5'd0:  m = 8'h80;
                5'd1:  m = 8'h3F;
                5'd2:  m = 8'h00;
                5'd4:  m = 8'hBF;
                5'd6:  m = 8'h3F;
                5'd7:  m = 8'h00;
                5'd9:  m = 8'hBF;
                5'd10: m = 8'h7F;
                5'd12: m = 8'h9F;
                5'd14: m = 8'hBF;
                5'd17: m = 8'h00;
                5'd18: m = 8'h00;
                5'd19: m = 8'hBF;
                5'd20: m = 8'h00;
                5'd21: m = 8'h00;
                5'd22: m = 8'h70;
                default: m = 8'hFF;
            endcase
            return m;
        end
    endfunction

endpackage

### hw/rtl/console_memory_bus_decoder_core.sv
// Top level of the console memory bus decoder.
// For each bus access, start is taken while busy is low, busy is high
// for the next cycle while the synchronous RAM read completes, and at the end of that
// cycle the result word stands on result for one cycle with done high. The receiver
// cannot stall; results that are not taken in their cycle are lost. No clearing pass
// after reset; RAM contents are undefined until written.
module console_memory_bus_decoder_core #(
    parameter int WORK_RAM_BYTES = cmbd_pkg::WORK_RAM_BYTES,
    parameter int SPRITE_RAM_BYTES = cmbd_pkg::SPRITE_RAM_BYTES
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cmbd_pkg::access_t access,
    output logic              done,
    output cmbd_pkg::result_t result
);
    cmbd_pkg::mem_req_t req;
    cmbd_pkg::result_t  res, res_reg;
    logic [7:0] rdata;
    logic       fire, busy_reg, done_reg, mem_rd_reg;

    assign fire = start && !busy_reg;

    cmbd_decoder u_dec (
        .clk(clk), .rst_n(rst_n), .fire(fire), .acc(access), .req(req), .res(res)
    );

    cmbd_ram_bank #(
        .WORK_RAM_BYTES(WORK_RAM_BYTES), .SPRITE_RAM_BYTES(SPRITE_RAM_BYTES)
    ) u_ram (
        .clk(clk), .en(fire), .req(req), .rdata(rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mem_rd_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= fire;
            done_reg <= busy_reg;
            if (fire) mem_rd_reg <= !req.wr && (req.sel != cmbd_pkg::SEL_NONE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire) res_reg <= res;
        else if (busy_reg && mem_rd_reg) res_reg.read_data <= rdata;
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign result = res_reg;

    a_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held");
    a_done_after: assert property (@(posedge clk) disable iff (!rst_n)
        fire |=> ##1 done) else $error("no result");
    a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> !busy) else $error("busy too long");
endmodule

### hw/rtl/cmbd_ram_bank.sv
// Synchronous RAMs of the decoder: video, work, sprite and high RAM.
module cmbd_ram_bank #(
    parameter int WORK_RAM_BYTES = cmbd_pkg::WORK_RAM_BYTES,
    parameter int SPRITE_RAM_BYTES = cmbd_pkg::SPRITE_RAM_BYTES
) (
    input  logic               clk,
    input  logic               en,
    input  cmbd_pkg::mem_req_t req,
    output logic [7:0]         rdata
);
    localparam int WA = $clog2(WORK_RAM_BYTES);
    localparam int SA = $clog2(SPRITE_RAM_BYTES);

    logic [7:0] vram [8192];
    logic [7:0] wram [WORK_RAM_BYTES];
    logic [7:0] oam  [SPRITE_RAM_BYTES];
    logic [7:0] hram [127];
    logic [7:0] rd_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            unique case (req.sel)
                cmbd_pkg::SEL_VRAM:
                begin
                    if (req.wr) vram[req.index] <= req.data;
                    else rd_reg <= vram[req.index];
                end
                cmbd_pkg::SEL_WRAM:
                begin
                    if (req.wr) wram[req.index[WA-1:0]] <= req.data;
                    else rd_reg <= wram[req.index[WA-1:0]];
                end
                cmbd_pkg::SEL_OAM:
                begin
                    if (req.wr) oam[req.index[SA-1:0]] <= req.data;
                    else rd_reg <= oam[req.index[SA-1:0]];
                end
                cmbd_pkg::SEL_HRAM:
                begin
                    if (req.wr) hram[req.index[6:0]] <= req.data;
                    else rd_reg <= hram[req.index[6:0]];
                end
                default:
                begin
                end
            endcase
        end
    end

    assign rdata = rd_reg;
endmodule

### hw/rtl/cmbd_decoder.sv
// Address decode and register file of the decoder; settles one access per call.
module cmbd_decoder (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               fire,
    input  cmbd_pkg::access_t  acc,
    output cmbd_pkg::mem_req_t req,
    output cmbd_pkg::result_t  res
);
    logic [7:0] disp_reg [10];
    logic [7:0] dma_reg, ser_reg, if_reg, ie_reg;
    logic       boot_reg;
    logic [7:0] if_next, ie_next;
    logic [3:0] slot;
    logic       slot_ok;
    logic [15:0] a;
    logic [15:0] off;
    logic        w;

    assign a = acc.address;
    assign w = acc.kind;

    always_comb
    begin
        slot_ok = 1'b1;
        slot = 4'd0;
        unique case (a[3:0])
            4'h0: slot = 4'd0;
            4'h1: slot = 4'd1;
            4'h2: slot = 4'd2;
            4'h3: slot = 4'd3;
            4'h5: slot = 4'd4;
            4'h7: slot = 4'd5;
            4'h8: slot = 4'd6;
            4'h9: slot = 4'd7;
            4'hA: slot = 4'd8;
            4'hB: slot = 4'd9;
            default: slot_ok = 1'b0;
        endcase
        if (a[15:4] != 12'hFF4) slot_ok = 1'b0;
    end

    always_comb
    begin
        res = '0;
        res.read_data = 8'hFF;
        res.target = cmbd_pkg::TGT_INTERNAL;
        req = '0;
        req.sel = cmbd_pkg::SEL_NONE;
        req.wr = w;
        req.data = acc.write_data;
        off = '0;
        if_next = if_reg;
        ie_next = ie_reg;
        priority if (a <= 16'h7FFF)
        begin
            res.read_data = acc.external_data;
            if (!w && a < 16'h0100 && boot_reg) res.target = cmbd_pkg::TGT_BOOT;
            else
            begin
                res.target = cmbd_pkg::TGT_CART;
                res.external_write = w;
            end
        end
        else if (a <= 16'h9FFF)
        begin
            req.sel = cmbd_pkg::SEL_VRAM;
            off = a - 16'h8000;
            req.index = off[12:0];
        end
        else if (a <= 16'hBFFF)
        begin
            res.target = cmbd_pkg::TGT_CART;
            res.read_data = acc.external_data;
            res.external_write = w;
        end
        else if (a <= 16'hFDFF)
        begin
            req.sel = cmbd_pkg::SEL_WRAM;
            off = (a <= 16'hDFFF) ? a - 16'hC000 : a - 16'hE000;
            req.index = off[12:0];
        end
        else if (a <= 16'hFE9F)
        begin
            req.sel = cmbd_pkg::SEL_OAM;
            off = a - 16'hFE00;
            req.index = off[12:0];
        end
        else if (a <= 16'hFEFF) res.target = cmbd_pkg::TGT_UNMAPPED;
        else if (a <= 16'hFF7F)
        begin
            priority if (a == 16'hFF00)
            begin
                res.target = cmbd_pkg::TGT_JOYPAD;
                res.read_data = acc.external_data;
            end
            else if (a == 16'hFF01 || a == 16'hFF50) begin end
            else if (a == 16'hFF02)
            begin
                if (w && acc.write_data == 8'h81)
                begin
                    res.serial_valid = 1'b1;
                    res.serial_out = ser_reg;
                end
            end
            else if (a >= 16'hFF04 && a <= 16'hFF07)
            begin
                res.target = cmbd_pkg::TGT_TIMER;
                res.read_data = acc.external_data;
                res.external_write = w;
            end
            else if (a == 16'hFF0F)
            begin
                if (w) if_next = acc.write_data;
                else res.read_data = if_reg;
            end
            else if (a >= 16'hFF10 && a <= 16'hFF3F)
            begin
                res.target = cmbd_pkg::TGT_AUDIO;
                res.external_write = w;
                // The mask table starts at FF10, so the low five address bits are rebased.
                if (a >= 16'hFF30) res.read_data = acc.external_data;
                else res.read_data = acc.external_data
                                     | cmbd_pkg::audio_mask(a[4:0] - 5'd16);
            end
            else if (slot_ok)
            begin
                if (slot == 4'd1)
                    res.read_data = {disp_reg[1][7:3], acc.display_mode_bits};
                else res.read_data = disp_reg[slot];
            end
            else if (a == 16'hFF44) res.read_data = acc.current_line;
            else if (a == 16'hFF46)
            begin
                res.read_data = dma_reg;
                if (w)
                begin
                    res.dma_start = 1'b1;
                    res.dma_page = acc.write_data;
                end
            end
            else res.target = cmbd_pkg::TGT_UNMAPPED;
        end
        else if (a <= 16'hFFFE)
        begin
            req.sel = cmbd_pkg::SEL_HRAM;
            off = a - 16'hFF80;
            req.index = off[12:0];
        end
        else
        begin
            if (w) ie_next = acc.write_data;
            else res.read_data = ie_reg;
        end
        if (w) res.read_data = 8'h00;
        res.interrupt_enable = ie_next;
        res.interrupt_flags = if_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 10; i++) disp_reg[i] <= 8'h00;
            dma_reg <= 8'h00;
            ser_reg <= 8'h00;
            if_reg <= 8'h00;
            ie_reg <= 8'h00;
            boot_reg <= 1'b1;
        end
        else if (fire)
        begin
            if_reg <= if_next;
            ie_reg <= ie_next;
            if (w)
            begin
                if (a == 16'hFF01) ser_reg <= acc.write_data;
                if (a == 16'hFF46) dma_reg <= acc.write_data;
                if (a == 16'hFF50 && acc.write_data != 8'h00) boot_reg <= 1'b0;
                if (slot_ok)
                    disp_reg[slot] <= (slot == 4'd1) ? (acc.write_data & 8'hF8)
                                                     : acc.write_data;
            end
        end
    end

    a_boot_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !boot_reg |=> !boot_reg) else $error("boot overlay came back");
    a_boot_target: assert property (@(posedge clk) disable iff (!rst_n)
        !boot_reg |-> res.target != cmbd_pkg::TGT_BOOT) else $error("boot target w/o overlay");
    a_dma_write: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && res.dma_start) |=> dma_reg == $past(acc.write_data))
        else $error("dma page not stored");
endmodule
